// File: rtl/pss_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pss_pkg: shared types and constants of the plucked string voice
// kinds, register indexes, saturation helper and controller/datapath structs
// ---------------------------------------------------------------------------
package pss_pkg;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_LOAD    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    localparam logic [2:0] REG_LOOP_LENGTH  = 3'd0;
    localparam logic [2:0] REG_LOWPASS_GAIN = 3'd1;
    localparam logic [2:0] REG_LOOP_DECAY   = 3'd2;
    localparam logic [2:0] REG_DISPERSION   = 3'd3;
    localparam logic [2:0] REG_BODY_MIX     = 3'd4;
    localparam logic [2:0] REG_BODY_FB      = 3'd5;
    localparam logic [2:0] REG_BODY_LENGTH  = 3'd6;

    localparam logic [14:0] RELEASE_DECAY_CAP = 15'd32112;
    localparam logic [14:0] Q15_ONE           = 15'd32767;
    localparam int          QUIET_LIMIT       = 24;

    // multiplier operand select
    typedef enum logic [2:0] {
        MUL_LP_NEW  = 3'd0,
        MUL_LP_OLD  = 3'd1,
        MUL_AP_X    = 3'd2,
        MUL_AP_Y    = 3'd3,
        MUL_DECAY   = 3'd4,
        MUL_BODY_FB = 3'd5,
        MUL_BODY_MX = 3'd6
    } mul_sel_t;

    typedef struct packed {
        logic     rd_string;   // read string store at pointer
        logic     take_delayed;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_clear;
        logic     lp_commit;
        logic     ap_commit;
        logic     string_wr;
        logic     body_wr;
        logic     body_rd;
        logic     finish;      // loop pointer, quiet count, result
        logic     restart;
        logic     clear_body;
        logic     clear_string; // sweep after reset
        logic     load_wr;
        logic     release_note;
    } dp_cmd_t;

    typedef struct packed {
        logic sounding;
        logic clear_done;
        logic init_done;
        logic ap_on;
        logic body_on;
    } dp_stat_t;

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767)
            return 16'sh7fff;
        else if (v < -48'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/pss_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pss_datapath: string and body stores, shared multiplier and filter state
// one 16x17 signed multiply per cycle while mul_en is set, into a 48-bit accumulator
// ---------------------------------------------------------------------------
module pss_datapath #(
    parameter int STRING_DEPTH = 2048,
    parameter int BODY_DEPTH   = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pss_pkg::dp_cmd_t    cmd,
    output pss_pkg::dp_stat_t        stat,
    input  wire logic [1:0]          in_kind,
    input  wire logic [10:0]         in_position,
    input  wire logic signed [15:0]  in_value,
    input  wire logic [10:0]         loop_length,
    input  wire logic [14:0]         lowpass_gain,
    input  wire logic [14:0]         loop_decay,
    input  wire logic [14:0]         dispersion_coef,
    input  wire logic [14:0]         body_mix,
    input  wire logic [14:0]         body_feedback,
    input  wire logic [7:0]          body_length,
    output logic signed [15:0]       res_sample,
    output logic                     res_active
);
    localparam int SAW = $clog2(STRING_DEPTH);
    localparam int BAW = $clog2(BODY_DEPTH);

    logic signed [15:0] string_mem [STRING_DEPTH];
    logic signed [15:0] body_mem   [BODY_DEPTH];

    logic [SAW-1:0] loop_ptr_reg;
    logic [BAW-1:0] body_ptr_reg;
    logic [BAW:0]   clr_cnt_reg;
    logic [SAW:0]   init_cnt_reg;
    logic signed [15:0] last_reg, lp_reg, ap_in_reg, ap_out_reg;
    logic signed [15:0] rd_data_reg, delayed_reg, body_rd_reg;
    logic [11:0] quiet_reg;
    logic        sounding_reg, let_go_reg;
    logic signed [47:0] acc_reg;
    logic signed [15:0] shaped_reg;

    logic signed [15:0] avg;
    logic signed [16:0] sum17;
    logic signed [15:0] ma;
    logic signed [16:0] mb;
    logic signed [32:0] prod;
    logic signed [47:0] acc_sum;
    logic signed [15:0] acc_sat;
    logic [14:0] decay;
    logic [BAW-1:0] back, body_rd_addr;
    logic [SAW:0] ptr_inc;
    logic quiet;
    logic [12:0] twice_len;
    logic [11:0] quiet_next;

    assign sum17 = 17'(delayed_reg) + 17'(last_reg);
    assign avg = sum17[16:1];
    assign decay = (let_go_reg && loop_decay > pss_pkg::RELEASE_DECAY_CAP)
                 ? pss_pkg::RELEASE_DECAY_CAP : loop_decay;
    assign back = BAW'(body_length);
    assign body_rd_addr = body_ptr_reg - back;

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (cmd.mul_sel)
            pss_pkg::MUL_LP_NEW:  begin ma = avg;         mb = {2'b0, lowpass_gain}; end
            pss_pkg::MUL_LP_OLD:  begin ma = lp_reg;
                                   mb = {2'b0, pss_pkg::Q15_ONE - lowpass_gain}; end
            pss_pkg::MUL_AP_X:    begin ma = shaped_reg;  mb = -{2'b0, dispersion_coef}; end
            pss_pkg::MUL_AP_Y:    begin ma = ap_out_reg;  mb = {2'b0, dispersion_coef}; end
            pss_pkg::MUL_DECAY:   begin ma = shaped_reg;  mb = {2'b0, decay}; end
            pss_pkg::MUL_BODY_FB: begin ma = body_rd_reg; mb = {2'b0, body_feedback}; end
            pss_pkg::MUL_BODY_MX: begin ma = body_rd_reg; mb = {2'b0, body_mix}; end
            default:              begin ma = '0;          mb = '0; end
        endcase
    end

    assign prod    = ma * mb;
    assign acc_sum = (cmd.acc_clear ? 48'sd0 : acc_reg) + 48'(prod);
    assign acc_sat = pss_pkg::sat16(acc_reg >>> 15);

    assign ptr_inc   = {1'b0, loop_ptr_reg} + 1'b1;
    assign quiet     = (delayed_reg > -16'(pss_pkg::QUIET_LIMIT))
                    && (delayed_reg < 16'(pss_pkg::QUIET_LIMIT));
    assign quiet_next = (quiet_reg == 12'hfff) ? quiet_reg : quiet_reg + 1'b1;
    assign twice_len = {1'b0, loop_length, 1'b0};

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.rd_string)
            rd_data_reg <= string_mem[loop_ptr_reg];
        if (cmd.clear_string)
            string_mem[init_cnt_reg[SAW-1:0]] <= '0;
        else if (cmd.string_wr)
            string_mem[loop_ptr_reg] <= acc_sat;
        else if (cmd.load_wr && (32'(in_position) < STRING_DEPTH))
            string_mem[SAW'(in_position)] <= in_value;
        if (cmd.body_rd)
            body_rd_reg <= body_mem[body_rd_addr];
        if (cmd.clear_body)
            body_mem[clr_cnt_reg[BAW-1:0]] <= '0;
        else if (cmd.body_wr)
            body_mem[body_ptr_reg] <= pss_pkg::sat16(48'(delayed_reg) + (acc_reg >>> 15));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_ptr_reg <= '0;
            body_ptr_reg <= '0;
            clr_cnt_reg  <= '0;
            init_cnt_reg <= '0;
            last_reg     <= '0;
            lp_reg       <= '0;
            ap_in_reg    <= '0;
            ap_out_reg   <= '0;
            quiet_reg    <= '0;
            sounding_reg <= 1'b0;
            let_go_reg   <= 1'b0;
            acc_reg      <= '0;
            shaped_reg   <= '0;
            delayed_reg  <= '0;
            res_sample   <= '0;
            res_active   <= 1'b0;
        end
        else
        begin
            if (cmd.mul_en)
                acc_reg <= acc_sum;
            if (cmd.take_delayed)
                delayed_reg <= rd_data_reg;
            if (cmd.lp_commit)
            begin
                lp_reg     <= acc_sat;
                shaped_reg <= acc_sat;
            end
            if (cmd.ap_commit)
            begin
                // acc holds -c*x + c*y1; add x1 * 32768
                ap_in_reg  <= shaped_reg;
                ap_out_reg <= pss_pkg::sat16((acc_reg + (48'(ap_in_reg) <<< 15)) >>> 15);
                shaped_reg <= pss_pkg::sat16((acc_reg + (48'(ap_in_reg) <<< 15)) >>> 15);
            end
            if (cmd.clear_string)
                init_cnt_reg <= init_cnt_reg + 1'b1;
            if (cmd.clear_body)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.release_note)
                let_go_reg <= 1'b1;
            if (cmd.body_wr)
                body_ptr_reg <= body_ptr_reg + 1'b1;
            if (cmd.finish)
            begin
                last_reg <= delayed_reg;
                loop_ptr_reg <= (ptr_inc >= (SAW+1)'(loop_length) ||
                                 32'(ptr_inc) >= STRING_DEPTH)
                              ? '0 : ptr_inc[SAW-1:0];
                if (quiet)
                begin
                    quiet_reg <= quiet_next;
                    res_active <= !(13'(quiet_next) > twice_len);
                    sounding_reg <= !(13'(quiet_next) > twice_len);
                end
                else
                begin
                    quiet_reg <= '0;
                    res_active <= 1'b1;
                end
                res_sample <= stat.body_on
                            ? pss_pkg::sat16(48'(delayed_reg) + (acc_reg >>> 15))
                            : delayed_reg;
            end
            if (cmd.restart)
            begin
                loop_ptr_reg <= '0;
                body_ptr_reg <= '0;
                last_reg     <= '0;
                lp_reg       <= '0;
                ap_in_reg    <= '0;
                ap_out_reg   <= '0;
                quiet_reg    <= '0;
                let_go_reg   <= 1'b0;
                sounding_reg <= 1'b1;
                clr_cnt_reg  <= '0;
            end
            if (in_kind == pss_pkg::KIND_TICK && !cmd.finish && !sounding_reg)
            begin
                res_sample <= '0;
                res_active <= 1'b0;
            end
        end
    end

    assign stat.sounding   = sounding_reg;
    assign stat.clear_done = clr_cnt_reg[BAW];
    assign stat.init_done  = init_cnt_reg == (SAW+1)'(STRING_DEPTH);
    assign stat.ap_on      = dispersion_coef != '0;
    assign stat.body_on    = body_mix != '0;
endmodule
`default_nettype wire

// File: rtl/pss_controller.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pss_controller: sequencer for one item
// steps the shared multiplier through the filter chain, then hands the result
// ---------------------------------------------------------------------------
module pss_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        in_kind,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pss_pkg::dp_cmd_t       cmd,
    input  wire pss_pkg::dp_stat_t stat
);
    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_READ  = 15'b000000000000010,
        S_TAKE  = 15'b000000000000100,
        S_LP0   = 15'b000000000001000,
        S_LP1   = 15'b000000000010000,
        S_AP0   = 15'b000000000100000,
        S_AP1   = 15'b000000001000000,
        S_AP2   = 15'b000000010000000,
        S_AP3   = 15'b000000100000000,
        S_DEC   = 15'b000001000000000,
        S_BODY  = 15'b000010000000000,
        S_FIN   = 15'b000100000000000,
        S_OUT   = 15'b001000000000000,
        S_CLEAR = 15'b010000000000000,
        S_INIT  = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.mul_sel    = pss_pkg::MUL_LP_NEW;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clear_string = !stat.init_done;
                if (stat.init_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_kind)
                        pss_pkg::KIND_LOAD:    cmd.load_wr = 1'b1;
                        pss_pkg::KIND_RELEASE: cmd.release_note = 1'b1;
                        pss_pkg::KIND_RESTART:
                        begin
                            cmd.restart = 1'b1;
                            state_next  = S_CLEAR;
                        end
                        default:
                            if (stat.sounding)
                                state_next = S_READ;
                            else
                                out_valid_next = 1'b1;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.clear_body = !stat.clear_done;
                if (stat.clear_done)
                    state_next = S_IDLE;
            end
            S_READ:
            begin
                cmd.rd_string = 1'b1;
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                cmd.take_delayed = 1'b1;
                state_next = S_LP0;
            end
            S_LP0:
            begin
                cmd.mul_en = 1'b1;
                cmd.acc_clear = 1'b1;
                cmd.mul_sel = pss_pkg::MUL_LP_NEW;
                state_next = S_LP1;
            end
            S_LP1:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = pss_pkg::MUL_LP_OLD;
                state_next = S_AP0;
            end
            S_AP0:
            begin
                cmd.lp_commit = 1'b1;
                state_next = stat.ap_on ? S_AP1 : S_DEC;
            end
            S_AP1:
            begin
                // two products: -c*x then c*y1, then commit
                cmd.mul_en = 1'b1;
                cmd.acc_clear = 1'b1;
                cmd.mul_sel = pss_pkg::MUL_AP_X;
                state_next = S_AP2;
            end
            S_AP2:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = pss_pkg::MUL_AP_Y;
                state_next = S_AP3;
            end
            S_AP3:
            begin
                cmd.ap_commit = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                cmd.mul_en = 1'b1;
                cmd.acc_clear = 1'b1;
                cmd.mul_sel = pss_pkg::MUL_DECAY;
                cmd.body_rd = 1'b1;
                state_next = S_BODY;
            end
            S_BODY:
            begin
                cmd.string_wr = 1'b1;
                cmd.mul_en = 1'b1;
                cmd.acc_clear = 1'b1;
                cmd.mul_sel = pss_pkg::MUL_BODY_FB;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.body_wr = stat.body_on;
                cmd.mul_en = 1'b1;
                cmd.acc_clear = 1'b1;
                cmd.mul_sel = pss_pkg::MUL_BODY_MX;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.finish = 1'b1;
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/plucked_string_voice_step.sv
`default_nettype none
// ---------------------------------------------------------------------------
// plucked_string_voice_step: Karplus-Strong string voice
// controller sequences a shared 16x17 multiplier over the loop filter chain
// ---------------------------------------------------------------------------
// After reset the string delay line is swept to zero with s_tready low. A
// tick while sounding steps through a registered delay line read and the
// single shared multiplier doing lowpass, allpass (with dispersion on), decay
// and body products one after another; the next transaction is taken the
// cycle after the result is accepted. A tick while silent shows its zero
// result in the cycle after acceptance. Load and release leave s_tready high
// and can follow back to back. Restart sweeps the body store before the next
// transaction can be taken.
module plucked_string_voice_step #(
    parameter int STRING_DEPTH = 2048,
    parameter int BODY_DEPTH   = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // position[10:0], value[26:11], zero pad
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // out_sample[15:0], voice_active[16], pad
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [10:0] loop_length_reg;
    logic [14:0] lowpass_gain_reg, loop_decay_reg, dispersion_reg;
    logic [14:0] body_mix_reg, body_fb_reg;
    logic [7:0]  body_length_reg;
    logic [2:0]  reg_idx;
    logic        cfg_we;
    pss_pkg::dp_cmd_t  cmd;
    pss_pkg::dp_stat_t stat;
    logic signed [15:0] res_sample;
    logic res_active;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_length_reg  <= 11'd2;
            lowpass_gain_reg <= 15'd32767;
            loop_decay_reg   <= 15'd32767;
            dispersion_reg   <= 15'd0;
            body_mix_reg     <= 15'd0;
            body_fb_reg      <= 15'd18022;
            body_length_reg  <= 8'd16;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx)
                pss_pkg::REG_LOOP_LENGTH:  loop_length_reg  <= pwdata[10:0];
                pss_pkg::REG_LOWPASS_GAIN: lowpass_gain_reg <= pwdata[14:0];
                pss_pkg::REG_LOOP_DECAY:   loop_decay_reg   <= pwdata[14:0];
                pss_pkg::REG_DISPERSION:   dispersion_reg   <= pwdata[14:0];
                pss_pkg::REG_BODY_MIX:     body_mix_reg     <= pwdata[14:0];
                pss_pkg::REG_BODY_FB:      body_fb_reg      <= pwdata[14:0];
                pss_pkg::REG_BODY_LENGTH:  body_length_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            pss_pkg::REG_LOOP_LENGTH:  prdata = 32'(loop_length_reg);
            pss_pkg::REG_LOWPASS_GAIN: prdata = 32'(lowpass_gain_reg);
            pss_pkg::REG_LOOP_DECAY:   prdata = 32'(loop_decay_reg);
            pss_pkg::REG_DISPERSION:   prdata = 32'(dispersion_reg);
            pss_pkg::REG_BODY_MIX:     prdata = 32'(body_mix_reg);
            pss_pkg::REG_BODY_FB:      prdata = 32'(body_fb_reg);
            pss_pkg::REG_BODY_LENGTH:  prdata = 32'(body_length_reg);
            default:                   prdata = '0;
        endcase
    end

    pss_controller u_ctrl (
        .clk, .rst_n,
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .cmd, .stat
    );

    pss_datapath #(.STRING_DEPTH(STRING_DEPTH), .BODY_DEPTH(BODY_DEPTH)) u_dp (
        .clk, .rst_n, .cmd, .stat,
        .in_kind        (s_tvalid && s_tready ? s_tuser : pss_pkg::KIND_LOAD),
        .in_position    (s_tdata[10:0]),
        .in_value       (s_tdata[26:11]),
        .loop_length    (loop_length_reg),
        .lowpass_gain   (lowpass_gain_reg),
        .loop_decay     (loop_decay_reg),
        .dispersion_coef(dispersion_reg),
        .body_mix       (body_mix_reg),
        .body_feedback  (body_fb_reg),
        .body_length    (body_length_reg),
        .res_sample, .res_active
    );

    assign m_tdata = {7'd0, res_active, res_sample};
endmodule
`default_nettype wire

// File: rtl/pss_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pss_checker: port-level checks of the voice
// result hold, one transaction in flight, silent ticks and zero padding
// ---------------------------------------------------------------------------
module pss_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result changed");
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("input taken with result pending");
    a_silent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[16] && $rose(m_tvalid) && m_tdata[15:0] != 16'd0
        |-> $past(s_tready) == 1'b0) else $error("silent tick with sample");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:17] == 7'd0) else $error("pad bits set");
endmodule

bind plucked_string_voice_step pss_checker u_chk (
    .clk, .rst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire

// File: tb/plucked_string_voice_step_test.sv
// ---------------------------------------------------------------------------
// plucked_string_voice_step_test: self-checking bench of the string voice
// drives tick, load, release and restart transactions on the input stream,
// predicts each tick's sample and voice flag, and checks the output stream
// ---------------------------------------------------------------------------
module plucked_string_voice_step_test;

    localparam int STR_N = 2048;
    localparam int BODY_N = 256;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [10:0]        position;
        logic signed [15:0] value;
    } voice_item_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               active;
    } voice_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    plucked_string_voice_step dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic signed [15:0] string_mem [STR_N];
    logic signed [15:0] body_mem [BODY_N];
    int unsigned loop_ptr, body_ptr, quiet_cnt;
    int last_in, lp_state, ap_in, ap_out;
    bit sounding, let_go;
    int unsigned cfg [7];

    voice_item_t pending_items[$];
    voice_out_t expected_samples[$];
    int errors = 0;
    int ticks_checked = 0;
    int items_sent = 0;
    int send_idle = 0;
    int recv_stall = 0;
    longint cycles = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic longint floor_shr(longint x, int s);
        return x >>> s;
    endfunction

    function automatic int clip16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return int'(v);
    endfunction

    task automatic predict_voice(input voice_item_t it);
        int dly, avg, shaped, outv, echo;
        int unsigned decay, nxt, rd;
        longint c, acc;
        voice_out_t r;
        if (it.kind == pss_pkg::KIND_LOAD)
        begin
            string_mem[it.position] = it.value;
            return;
        end
        if (it.kind == pss_pkg::KIND_RELEASE)
        begin
            let_go = 1;
            return;
        end
        if (it.kind == pss_pkg::KIND_RESTART)
        begin
            loop_ptr = 0; body_ptr = 0; last_in = 0; lp_state = 0;
            ap_in = 0; ap_out = 0; quiet_cnt = 0; let_go = 0; sounding = 1;
            foreach (body_mem[i]) body_mem[i] = '0;
            return;
        end
        if (!sounding)
        begin
            r.sample = '0;
            r.active = 1'b0;
            expected_samples.push_back(r);
            return;
        end
        decay = (let_go && cfg[pss_pkg::REG_LOOP_DECAY] > 32112)
              ? 32112 : cfg[pss_pkg::REG_LOOP_DECAY];
        loop_ptr = loop_ptr % STR_N;
        dly = string_mem[loop_ptr];
        avg = int'(floor_shr(longint'(dly) + last_in, 1));
        last_in = dly;
        lp_state = clip16(floor_shr(longint'(avg) * cfg[pss_pkg::REG_LOWPASS_GAIN]
            + longint'(lp_state) * (32767 - cfg[pss_pkg::REG_LOWPASS_GAIN]), 15));
        shaped = lp_state;
        if (cfg[pss_pkg::REG_DISPERSION] != 0)
        begin
            c = cfg[pss_pkg::REG_DISPERSION];
            acc = -c * shaped + longint'(ap_in) * 32768 + c * ap_out;
            ap_in = shaped;
            ap_out = clip16(floor_shr(acc, 15));
            shaped = ap_out;
        end
        string_mem[loop_ptr] = clip16(floor_shr(longint'(shaped) * decay, 15));
        outv = dly;
        if (cfg[pss_pkg::REG_BODY_MIX] != 0)
        begin
            rd = (body_ptr + BODY_N - (cfg[pss_pkg::REG_BODY_LENGTH] % BODY_N)) % BODY_N;
            echo = body_mem[rd];
            body_mem[body_ptr] = clip16(longint'(dly)
                + floor_shr(longint'(echo) * cfg[pss_pkg::REG_BODY_FB], 15));
            body_ptr = (body_ptr + 1) % BODY_N;
            outv = clip16(longint'(dly)
                + floor_shr(longint'(echo) * cfg[pss_pkg::REG_BODY_MIX], 15));
        end
        nxt = loop_ptr + 1;
        if (nxt >= cfg[pss_pkg::REG_LOOP_LENGTH] || nxt >= STR_N)
            nxt = 0;
        loop_ptr = nxt;
        if (dly > -pss_pkg::QUIET_LIMIT && dly < pss_pkg::QUIET_LIMIT)
        begin
            if (quiet_cnt < 4095)
                quiet_cnt++;
            if (quiet_cnt > 2 * cfg[pss_pkg::REG_LOOP_LENGTH])
                sounding = 0;
        end
        else
            quiet_cnt = 0;
        r.sample = outv[15:0];
        r.active = sounding;
        expected_samples.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // driver: predicts at the accepting edge
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_voice(pending_items.pop_front());
                items_sent++;
            end
            if ((!s_tvalid || s_tready) && pending_items.size() > 0
                && (s_tvalid && s_tready ? pending_items.size() > 0 : 1))
            begin
                if (send_idle != 0 && $urandom_range(99) < send_idle)
                    s_tvalid <= 1'b0;
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'd0, pending_items[0].value, pending_items[0].position};
                    s_tuser <= pending_items[0].kind;
                end
            end
            else if (s_tvalid && s_tready)
                s_tvalid <= 1'b0;
            m_tready <= !(recv_stall != 0 && $urandom_range(99) < recv_stall);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        voice_out_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_samples.size() == 0)
                report_mismatch("unexpected result", int'(m_tdata[16:0]), -1);
            else
            begin
                w = expected_samples.pop_front();
                ticks_checked++;
                if (m_tdata[15:0] !== w.sample)
                    report_mismatch("out_sample", $signed(m_tdata[15:0]), w.sample);
                if (m_tdata[16] !== w.active)
                    report_mismatch("voice_active", m_tdata[16], w.active);
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("plucked_string_voice_step_test NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cfg[idx] = val;
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_samples.size() > 0)
            @(posedge clk);
        // restart sweep of the body store may still run
        repeat (BODY_N + 40) @(posedge clk);
    endtask

    task automatic add_item(input logic [1:0] k, input logic [10:0] p,
                            input logic signed [15:0] v);
        voice_item_t it;
        it.kind = k; it.position = p; it.value = v;
        pending_items.push_back(it);
    endtask

    // a pluck: excitation burst, restart, a run of ticks with the odd release or load
    task automatic queue_pluck(input int n_ticks, input int unsigned len);
        int n_load;
        n_load = $urandom_range(8, 1);
        for (int i = 0; i < n_load; i++)
            add_item(pss_pkg::KIND_LOAD, ($urandom_range(3) == 0) ? 11'($urandom)
                     : 11'($urandom_range(len - 1)), 16'($urandom));
        add_item(pss_pkg::KIND_RESTART, 11'($urandom), 16'($urandom));
        for (int i = 0; i < n_ticks; i++)
        begin
            case ($urandom_range(29))
                0: add_item(pss_pkg::KIND_RELEASE, 11'($urandom), 16'($urandom));
                1: add_item(pss_pkg::KIND_LOAD, 11'($urandom), 16'($urandom));
                default: add_item(pss_pkg::KIND_TICK, 11'($urandom), 16'($urandom));
            endcase
        end
    endtask

    task automatic random_config(input int unsigned len);
        write_reg(pss_pkg::REG_LOOP_LENGTH, len);
        write_reg(pss_pkg::REG_LOWPASS_GAIN, $urandom_range(1) ? 32767 - $urandom_range(8000)
                  : $urandom_range(32767));
        write_reg(pss_pkg::REG_LOOP_DECAY, $urandom_range(32767, 28000));
        write_reg(pss_pkg::REG_DISPERSION, $urandom_range(1) ? 0 : $urandom_range(32767));
        write_reg(pss_pkg::REG_BODY_MIX, $urandom_range(1) ? 0 : $urandom_range(32767));
        write_reg(pss_pkg::REG_BODY_FB, $urandom_range(32767));
        write_reg(pss_pkg::REG_BODY_LENGTH, $urandom_range(255));
    endtask

    initial
    begin
        int unsigned len;
        cfg[0] = 2; cfg[1] = 32767; cfg[2] = 32767; cfg[3] = 0;
        cfg[4] = 0; cfg[5] = 18022; cfg[6] = 16;
        foreach (string_mem[i]) string_mem[i] = '0;
        foreach (body_mem[i]) body_mem[i] = '0;
        loop_ptr = 0; body_ptr = 0; last_in = 0; lp_state = 0; ap_in = 0;
        ap_out = 0; quiet_cnt = 0; sounding = 0; let_go = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: silent tick, extremes, release, restart
        add_item(pss_pkg::KIND_TICK, 11'd0, 16'sd0);
        add_item(pss_pkg::KIND_LOAD, 11'd0, 16'sh7fff);
        add_item(pss_pkg::KIND_LOAD, 11'd1, 16'sh8000);
        add_item(pss_pkg::KIND_LOAD, 11'd2047, 16'sh7fff);
        add_item(pss_pkg::KIND_RELEASE, 11'd2047, 16'shffff);
        add_item(pss_pkg::KIND_TICK, 11'd0, 16'sd0);
        add_item(pss_pkg::KIND_RESTART, 11'd0, 16'sd0);
        for (int i = 0; i < 8; i++)
            add_item(pss_pkg::KIND_TICK, 11'd0, 16'sd0);
        add_item(pss_pkg::KIND_RELEASE, 11'd0, 16'sd0);
        for (int i = 0; i < 8; i++)
            add_item(pss_pkg::KIND_TICK, 11'h7ff, 16'shffff);
        wait_drained();

        // extremes of the registers, including the small loop lengths
        write_reg(pss_pkg::REG_LOOP_LENGTH, 0);
        write_reg(pss_pkg::REG_LOWPASS_GAIN, 0);
        write_reg(pss_pkg::REG_LOOP_DECAY, 0);
        write_reg(pss_pkg::REG_DISPERSION, 32767);
        write_reg(pss_pkg::REG_BODY_MIX, 32767);
        write_reg(pss_pkg::REG_BODY_FB, 32767);
        write_reg(pss_pkg::REG_BODY_LENGTH, 0);
        queue_pluck(20, 2);
        wait_drained();
        write_reg(pss_pkg::REG_LOOP_LENGTH, 1);
        write_reg(pss_pkg::REG_LOWPASS_GAIN, 32767);
        write_reg(pss_pkg::REG_LOOP_DECAY, 32767);
        write_reg(pss_pkg::REG_BODY_LENGTH, 255);
        queue_pluck(20, 2);
        wait_drained();
        write_reg(pss_pkg::REG_LOOP_LENGTH, 2047);
        queue_pluck(10, 2047);
        wait_drained();

        // random phases with varying flow control
        for (int ph = 0; ph < 16; ph++)
        begin
            case (ph % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 85; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 85; end
                default: begin send_idle = 9; recv_stall = 9; end
            endcase
            len = ($urandom_range(3) == 0) ? $urandom_range(2047, 2) : $urandom_range(24, 2);
            random_config(len);
            for (int k = 0; k < 3; k++)
                queue_pluck($urandom_range(40, 10), len);
            wait_drained();
        end

        $display("covered %0d transactions, %0d tick results checked", items_sent, ticks_checked);
        $display("under reset, extreme and 16 random register settings with stalls");
        if (errors == 0)
            $display("plucked_string_voice_step_test OK");
        else
            $display("plucked_string_voice_step_test NOT OK");
        $finish;
    end
endmodule

// File: sim.f
rtl/pss_pkg.sv
rtl/pss_datapath.sv
rtl/pss_controller.sv
rtl/plucked_string_voice_step.sv
rtl/pss_checker.sv
tb/plucked_string_voice_step_test.sv
